// File: sv/fpund_pkg.sv
// Shared definitions for the fisheye point undistortion block.
// Holds number-format constants, sequencer codes and the CORDIC angle table.
// No dependencies.
package fpund_pkg;

	localparam int CORDIC_STEPS   = 40;
	localparam int MAX_ITERATIONS = 10;
	localparam int IT_W           = $clog2(MAX_ITERATIONS + 1);
	localparam int DLEN_DELTA     = 64 + 28;
	localparam int DLEN_SCALE     = 64 + 40;

	localparam logic signed [63:0] LIM     = 64'sh0400_0000_0000_0000;
	localparam logic signed [63:0] ONE_Q28 = 64'sh0000_0000_1000_0000;
	localparam logic signed [63:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
	localparam logic signed [63:0] TOL_Q28 = 64'sd19;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOCONV   = 2'd1,
		STAT_NEGSCALE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SQIN, S_SQRT, S_ATAN, S_NEWT, S_MUL,
		S_MULF, S_DIV, S_DIVF, S_RED, S_ROT, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		MOP_POW, MOP_TERM, MOP_CT, MOP_OX, MOP_OY
	} mop_t;

	typedef enum logic {
		DOP_DELTA, DOP_SCALE
	} dop_t;

	typedef logic signed [63:0] angle_tab_t [CORDIC_STEPS];

	// atan(1/n) in Q.60 by its alternating series; n is 3 or 2^shift_n
	function automatic logic signed [63:0] atan_recip(input int shift_n, input bit by_three);
		logic [63:0]        p;
		logic [63:0]        t;
		logic signed [63:0] sum;
		p   = by_three ? (64'd1 << 60) / 64'd3 : (64'd1 << 60) >> shift_n;
		sum = '0;
		for (int k = 0; k < 64; k++) begin
			if (p != 64'd0) begin
				t   = p / 64'(2 * k + 1);
				sum = k[0] ? sum - signed'(t) : sum + signed'(t);
				p   = by_three ? p / 64'd9 : p >> (2 * shift_n);
			end
		end
		return sum;
	endfunction

	function automatic angle_tab_t build_angle_tab();
		angle_tab_t tab;
		tab[0] = atan_recip(1, 1'b0) + atan_recip(0, 1'b1);
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			tab[i] = atan_recip(i, 1'b0);
		end
		return tab;
	endfunction

	localparam angle_tab_t ANGLE_TAB = build_angle_tab();
	localparam logic signed [63:0] HALF_PI_Q60 = 2 * ANGLE_TAB[0];
	localparam logic signed [63:0] PI_Q60      = 4 * ANGLE_TAB[0];

endpackage

// File: sv/fisheye_point_undistort.sv
// Fisheye point undistortion: square root, CORDIC arctangent, Newton inversion,
// CORDIC tangent and scaling, all on one shared 32x32 multiplier, divider and shifter.
// Depends on fpund_pkg.
//
//  channel | signals                         | direction
//  --------+---------------------------------+-----------
//  input   | in_valid, in_stall, x_in, y_in  | request in
//  output  | out_valid, out_stall, x_out,    | result out
//          | y_out, status                   |
//  config  | wr_en, wr_index, wr_data        | write in
//
// Each request runs the square root and up to MAX_ITERATIONS Newton steps; a zero radius
// skips the arctangent, a failed Newton search skips tangent and scaling, and a negative
// scale skips the scaling. A Newton step is 16 multiplies and a bit-serial division.
// in_stall is high from acceptance until the result is in the output register.
// A result waiting under out_stall does not stop the next request being accepted.
// arst_n clears the sequencer, the output valid and the coefficients.
module fisheye_point_undistort (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic [1:0]         status,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] clamp58(input logic signed [63:0] v);
		if (v > fpund_pkg::LIM)
			return fpund_pkg::LIM;
		else if (v < -fpund_pkg::LIM)
			return -fpund_pkg::LIM;
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	fpund_pkg::state_t  state_q, state_d;
	logic signed [31:0] k_q [4];
	logic signed [31:0] x_q, y_q;
	logic               sq_c_q;
	logic [63:0]        sqn_q, sres_q;
	logic [4:0]         si_q;
	logic [31:0]        r_q;
	logic signed [63:0] cx_q, cy_q, cz_q;
	logic [5:0]         ci_q;
	logic signed [31:0] theta_q;
	logic signed [63:0] pw_q, thd_acc_q, fp_acc_q, thd_q, scale_q;
	logic [3:0]         e_q;
	logic [fpund_pkg::IT_W-1:0] it_q;

	fpund_pkg::mop_t    mop_q;
	logic [63:0]        ma_q, mb_q;
	logic               mneg_q;
	logic [1:0]         mc_q;
	logic [127:0]       acc_q;

	fpund_pkg::dop_t    dop_q;
	logic [63:0]        ud_q, nsh_q, rem_q;
	logic [59:0]        q_q;
	logic               ovf_q, dneg_q;
	logic [6:0]         dc_q;

	logic signed [31:0] ox_q, oy_q, xo_q, yo_q;
	fpund_pkg::status_t st_q, so_q;
	logic               out_valid_q;

	// control requests from the sequencer
	logic               mul_go, div_go;
	fpund_pkg::mop_t    mul_op;
	fpund_pkg::dop_t    div_op;
	logic signed [63:0] mul_a, mul_b, div_num, div_den;

	// shared datapath
	logic [31:0]        op32a, op32b, xm32, ym32;
	logic [63:0]        mul32;
	logic [127:0]       pp_sh, mul_shv;
	logic [63:0]        mul_mag;
	logic signed [63:0] mul_res;
	logic signed [63:0] dx, dy, ctab, cx_n, cy_n, cz_n, tz;
	logic               cplus;
	logic [63:0]        sbit, strial, sqn_n, sres_n;
	logic               sge;
	logic [3:0]         em2;
	logic [1:0]         kidx;
	logic signed [63:0] thd_sum, thd_cl, fp_cl, fp_term, r28, theta_sx, theta_sum;
	logic [64:0]        rem_sh, rem_n;
	logic               dge, div_last;
	logic [63:0]        div_mag;
	logic signed [63:0] div_res;
	logic               delta_small, it_last, out_free;

	assign xm32  = x_q[31] ? 32'(-x_q) : 32'(x_q);
	assign ym32  = y_q[31] ? 32'(-y_q) : 32'(y_q);
	assign op32a = (state_q == fpund_pkg::S_SQIN) ? (sq_c_q ? ym32 : xm32)
	             : (mc_q[1] ? ma_q[63:32] : ma_q[31:0]);
	assign op32b = (state_q == fpund_pkg::S_SQIN) ? (sq_c_q ? ym32 : xm32)
	             : (mc_q[0] ? mb_q[63:32] : mb_q[31:0]);
	assign mul32 = op32a * op32b;

	always_comb begin
		unique case (mc_q)
			2'd0:    pp_sh = {64'd0, mul32};
			2'd3:    pp_sh = {mul32, 64'd0};
			default: pp_sh = {32'd0, mul32, 32'd0};
		endcase
		unique case (mop_q)
			fpund_pkg::MOP_TERM:                  mul_shv = acc_q >> 24;
			fpund_pkg::MOP_OX, fpund_pkg::MOP_OY: mul_shv = acc_q >> 40;
			default:                              mul_shv = acc_q >> 28;
		endcase
	end
	assign mul_mag = (mul_shv > 128'(fpund_pkg::LIM)) ? 64'(fpund_pkg::LIM) : mul_shv[63:0];
	assign mul_res = mneg_q ? -signed'(mul_mag) : signed'(mul_mag);

	// one CORDIC micro-rotation, vectoring for atan and rotating for tan
	assign dx    = cy_q >>> ci_q;
	assign dy    = cx_q >>> ci_q;
	assign ctab  = fpund_pkg::ANGLE_TAB[ci_q];
	assign cplus = (state_q == fpund_pkg::S_ATAN) ? !cy_q[63] : cz_q[63];
	assign cx_n  = cplus ? cx_q + dx : cx_q - dx;
	assign cy_n  = cplus ? cy_q - dy : cy_q + dy;
	assign cz_n  = cplus ? cz_q + ctab : cz_q - ctab;
	assign tz    = cz_n + 64'sh0000_0000_8000_0000;

	assign sbit   = 64'd1 << (6'd62 - {si_q, 1'b0});
	assign strial = sres_q + sbit;
	assign sge    = sqn_q >= strial;
	assign sqn_n  = sge ? sqn_q - strial : sqn_q;
	assign sres_n = sge ? (sres_q >> 1) + sbit : sres_q >> 1;

	assign em2      = e_q - 4'd2;
	assign kidx     = em2[2:1];
	assign theta_sx = 64'(theta_q);
	assign r28      = signed'({24'd0, r_q, 8'd0});
	assign thd_sum  = thd_acc_q + mul_res;
	assign thd_cl   = clamp58(thd_sum);
	assign fp_cl    = clamp58(fp_acc_q);
	always_comb begin
		unique case (e_q)
			4'd2:    fp_term = (mul_res <<< 1) + mul_res;
			4'd4:    fp_term = (mul_res <<< 2) + mul_res;
			4'd6:    fp_term = (mul_res <<< 3) - mul_res;
			default: fp_term = (mul_res <<< 3) + mul_res;
		endcase
	end

	// restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q, nsh_q[63]};
	assign dge      = rem_sh >= {1'b0, ud_q};
	assign rem_n    = dge ? rem_sh - {1'b0, ud_q} : rem_sh;
	assign div_last = dc_q == ((dop_q == fpund_pkg::DOP_DELTA) ? 7'(fpund_pkg::DLEN_DELTA - 1)
	                                                            : 7'(fpund_pkg::DLEN_SCALE - 1));
	assign div_mag  = (ovf_q || q_q > 60'(fpund_pkg::LIM)) ? 64'(fpund_pkg::LIM) : {4'd0, q_q};
	assign div_res  = dneg_q ? -signed'(div_mag) : signed'(div_mag);

	assign delta_small = (div_res > -fpund_pkg::TOL_Q28) && (div_res < fpund_pkg::TOL_Q28);
	assign theta_sum   = theta_sx + div_res;
	assign it_last     = it_q == fpund_pkg::IT_W'(fpund_pkg::MAX_ITERATIONS - 1);
	assign out_free    = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpund_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_go  = 1'b0;
		mul_op  = fpund_pkg::MOP_POW;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_op  = fpund_pkg::DOP_DELTA;
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			fpund_pkg::S_IDLE: begin
				if (in_valid)
					state_d = fpund_pkg::S_SQIN;
			end
			fpund_pkg::S_SQIN: begin
				if (sq_c_q)
					state_d = fpund_pkg::S_SQRT;
			end
			fpund_pkg::S_SQRT: begin
				if (si_q == 5'd31)
					state_d = (sres_n == 64'd0) ? fpund_pkg::S_NEWT : fpund_pkg::S_ATAN;
			end
			fpund_pkg::S_ATAN: begin
				if (ci_q == 6'(fpund_pkg::CORDIC_STEPS - 1))
					state_d = fpund_pkg::S_NEWT;
			end
			fpund_pkg::S_NEWT: begin
				mul_go  = 1'b1;
				mul_op  = fpund_pkg::MOP_POW;
				mul_a   = theta_sx;
				mul_b   = theta_sx;
				state_d = fpund_pkg::S_MUL;
			end
			fpund_pkg::S_MUL: begin
				if (mc_q == 2'd3)
					state_d = fpund_pkg::S_MULF;
			end
			fpund_pkg::S_MULF: begin
				unique case (mop_q)
					fpund_pkg::MOP_POW: begin
						mul_go  = 1'b1;
						mul_op  = fpund_pkg::MOP_TERM;
						mul_a   = 64'(k_q[kidx]);
						mul_b   = mul_res;
						state_d = fpund_pkg::S_MUL;
					end
					fpund_pkg::MOP_TERM: begin
						if (e_q == 4'd9) begin
							div_go  = 1'b1;
							div_op  = fpund_pkg::DOP_DELTA;
							div_num = r28 - thd_cl;
							div_den = fp_cl;
							state_d = (fp_cl == 64'sd0) ? fpund_pkg::S_DIVF : fpund_pkg::S_DIV;
						end else begin
							mul_go  = 1'b1;
							mul_op  = fpund_pkg::MOP_POW;
							mul_a   = pw_q;
							mul_b   = theta_sx;
							state_d = fpund_pkg::S_MUL;
						end
					end
					fpund_pkg::MOP_CT: begin
						div_go  = 1'b1;
						div_op  = fpund_pkg::DOP_SCALE;
						div_num = cy_q;
						div_den = mul_res;
						state_d = (mul_res == 64'sd0) ? fpund_pkg::S_DIVF : fpund_pkg::S_DIV;
					end
					fpund_pkg::MOP_OX: begin
						mul_go  = 1'b1;
						mul_op  = fpund_pkg::MOP_OY;
						mul_a   = 64'(y_q);
						mul_b   = scale_q;
						state_d = fpund_pkg::S_MUL;
					end
					default: begin
						state_d = fpund_pkg::S_DONE;
					end
				endcase
			end
			fpund_pkg::S_DIV: begin
				if (div_last)
					state_d = fpund_pkg::S_DIVF;
			end
			fpund_pkg::S_DIVF: begin
				if (dop_q == fpund_pkg::DOP_DELTA) begin
					if (delta_small) begin
						if (thd_q == 64'sd0) begin
							mul_go  = 1'b1;
							mul_op  = fpund_pkg::MOP_OX;
							mul_a   = 64'(x_q);
							mul_b   = fpund_pkg::ONE_Q40;
							state_d = fpund_pkg::S_MUL;
						end else begin
							state_d = fpund_pkg::S_RED;
						end
					end else begin
						state_d = it_last ? fpund_pkg::S_DONE : fpund_pkg::S_NEWT;
					end
				end else if (div_res < 64'sd0) begin
					state_d = fpund_pkg::S_DONE;
				end else begin
					mul_go  = 1'b1;
					mul_op  = fpund_pkg::MOP_OX;
					mul_a   = 64'(x_q);
					mul_b   = div_res;
					state_d = fpund_pkg::S_MUL;
				end
			end
			fpund_pkg::S_RED: begin
				if (!(cz_q > fpund_pkg::HALF_PI_Q60) && !(cz_q < -fpund_pkg::HALF_PI_Q60))
					state_d = fpund_pkg::S_ROT;
			end
			fpund_pkg::S_ROT: begin
				if (ci_q == 6'(fpund_pkg::CORDIC_STEPS - 1)) begin
					mul_go  = 1'b1;
					mul_op  = fpund_pkg::MOP_CT;
					mul_a   = cx_n;
					mul_b   = thd_q;
					state_d = fpund_pkg::S_MUL;
				end
			end
			default: begin
				if (out_free)
					state_d = fpund_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				k_q[i] <= '0;
		end else if (wr_en) begin
			k_q[wr_index] <= wr_data;
		end
	end

	// shared multiplier and divider
	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q   <= mag64(mul_a);
			mb_q   <= mag64(mul_b);
			mneg_q <= mul_a[63] ^ mul_b[63];
			mop_q  <= mul_op;
			mc_q   <= 2'd0;
			acc_q  <= '0;
		end else if (state_q == fpund_pkg::S_MUL) begin
			acc_q <= acc_q + pp_sh;
			mc_q  <= mc_q + 2'd1;
		end
		if (div_go) begin
			ud_q   <= mag64(div_den);
			nsh_q  <= mag64(div_num);
			rem_q  <= '0;
			q_q    <= (div_den == 64'sd0 && div_num != 64'sd0) ? 60'(fpund_pkg::LIM) : '0;
			ovf_q  <= 1'b0;
			dneg_q <= div_num[63] ^ div_den[63];
			dop_q  <= div_op;
			dc_q   <= '0;
		end else if (state_q == fpund_pkg::S_DIV) begin
			rem_q <= rem_n[63:0];
			q_q   <= {q_q[58:0], dge};
			ovf_q <= ovf_q | q_q[59];
			nsh_q <= nsh_q << 1;
			dc_q  <= dc_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fpund_pkg::S_IDLE: begin
				x_q    <= x_in;
				y_q    <= y_in;
				sq_c_q <= 1'b0;
			end
			fpund_pkg::S_SQIN: begin
				sq_c_q <= 1'b1;
				sqn_q  <= sq_c_q ? sqn_q + mul32 : mul32;
				sres_q <= '0;
				si_q   <= '0;
			end
			fpund_pkg::S_SQRT: begin
				sqn_q   <= sqn_n;
				sres_q  <= sres_n;
				si_q    <= si_q + 5'd1;
				r_q     <= sres_n[31:0];
				theta_q <= '0;
				it_q    <= '0;
				cx_q    <= fpund_pkg::ONE_Q40;
				cy_q    <= signed'({12'd0, sres_n[31:0], 20'd0});
				cz_q    <= '0;
				ci_q    <= '0;
			end
			fpund_pkg::S_ATAN: begin
				cx_q    <= cx_n;
				cy_q    <= cy_n;
				cz_q    <= cz_n;
				ci_q    <= ci_q + 6'd1;
				theta_q <= tz[63:32];
			end
			fpund_pkg::S_NEWT: begin
				pw_q      <= theta_sx;
				e_q       <= 4'd2;
				thd_acc_q <= theta_sx;
				fp_acc_q  <= fpund_pkg::ONE_Q28;
			end
			fpund_pkg::S_MULF: begin
				unique case (mop_q)
					fpund_pkg::MOP_POW: pw_q <= mul_res;
					fpund_pkg::MOP_TERM: begin
						if (e_q[0])
							thd_acc_q <= thd_sum;
						else
							fp_acc_q <= fp_acc_q + fp_term;
						e_q   <= e_q + 4'd1;
						thd_q <= thd_cl;
					end
					fpund_pkg::MOP_OX: ox_q <= sat32(mul_res);
					fpund_pkg::MOP_OY: begin
						oy_q <= sat32(mul_res);
						st_q <= fpund_pkg::STAT_OK;
					end
					default: begin
					end
				endcase
			end
			fpund_pkg::S_DIVF: begin
				if (dop_q == fpund_pkg::DOP_DELTA) begin
					if (delta_small) begin
						scale_q <= fpund_pkg::ONE_Q40;
						cz_q    <= signed'({theta_q, 32'd0});
					end else begin
						theta_q <= sat32(theta_sum);
						it_q    <= it_q + 1'b1;
						ox_q    <= x_q;
						oy_q    <= y_q;
						st_q    <= fpund_pkg::STAT_NOCONV;
					end
				end else begin
					scale_q <= div_res;
					ox_q    <= x_q;
					oy_q    <= y_q;
					st_q    <= fpund_pkg::STAT_NEGSCALE;
				end
			end
			fpund_pkg::S_RED: begin
				// fold the angle into [-pi/2, pi/2] before rotating
				if (cz_q > fpund_pkg::HALF_PI_Q60)
					cz_q <= cz_q - fpund_pkg::PI_Q60;
				else if (cz_q < -fpund_pkg::HALF_PI_Q60)
					cz_q <= cz_q + fpund_pkg::PI_Q60;
				cx_q <= fpund_pkg::ONE_Q40;
				cy_q <= '0;
				ci_q <= '0;
			end
			fpund_pkg::S_ROT: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
				ci_q <= ci_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == fpund_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fpund_pkg::S_DONE && out_free) begin
			xo_q <= ox_q;
			yo_q <= oy_q;
			so_q <= st_q;
		end
	end

	assign in_stall  = state_q != fpund_pkg::S_IDLE;
	assign out_valid = out_valid_q;
	assign x_out     = xo_q;
	assign y_out     = yo_q;
	assign status    = so_q;

endmodule

// File: sv/fpund_checker.sv
// Port-level checks for the fisheye point undistortion block.
// Bound to fisheye_point_undistort; depends on fpund_pkg.
module fpund_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] x_out,
	input logic [1:0]  status
);

	// only the three defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == fpund_pkg::STAT_OK || status == fpund_pkg::STAT_NOCONV
		               || status == fpund_pkg::STAT_NEGSCALE))
		else $error("undefined status code");

	// one request at a time: busy straight after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while busy");

	// a result never appears on the cycle after its request
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result too early");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(x_out) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind fisheye_point_undistort fpund_checker u_fpund_checker (.*);

// File: tb/fisheye_point_undistort_test.sv
// Self-checking bench for fisheye_point_undistort: random and directed points under several
// coefficient sets, each result checked against a bit-true fixed-point predictor.
// Depends on fpund_pkg and the fisheye_point_undistort RTL.
module fisheye_point_undistort_test;

	localparam logic [1:0] REG_K1 = 2'd0;
	localparam logic [1:0] REG_K2 = 2'd1;
	localparam logic [1:0] REG_K3 = 2'd2;
	localparam logic [1:0] REG_K4 = 2'd3;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		fpund_pkg::status_t st;
	} undist_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] x_in = '0;
	logic signed [31:0] y_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic [1:0]         status;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = '0;
	logic [31:0]        wr_data = '0;

	point_t             pending_points[$];
	undist_t            expected_points[$];
	logic signed [31:0] coeff[4] = '{default: '0};
	int                 n_errors = 0;
	int                 n_results = 0;
	bit                 calm = 1'b0;
	int                 tx_gap = 0;
	int                 rx_gap = 0;
	int                 hold_cnt = 0;
	bit                 hold_done = 1'b0;

	fisheye_point_undistort dut (.*);

	always #10 clk = ~clk;

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] clamp58(logic signed [63:0] v);
		return v > fpund_pkg::LIM ? fpund_pkg::LIM
		     : (v < -fpund_pkg::LIM ? -fpund_pkg::LIM : v);
	endfunction

	// (a*b) >> sh toward zero, magnitude capped
	function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b,
			int sh);
		logic [127:0]       p;
		logic [127:0]       cap;
		logic signed [63:0] r;
		cap = 128'(fpund_pkg::LIM);
		p   = {64'd0, mag64(a)} * {64'd0, mag64(b)};
		p   = p >> sh;
		r   = (p > cap) ? fpund_pkg::LIM : signed'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	// (num << sh) / den toward zero, magnitude capped
	function automatic logic signed [63:0] fx_div(logic signed [63:0] num,
			logic signed [63:0] den, int sh);
		logic [63:0]        un, ud, q, rem, cap;
		logic signed [63:0] r;
		if (den == 0) begin
			return num == 0 ? 64'sd0 : (num < 0 ? -fpund_pkg::LIM : fpund_pkg::LIM);
		end
		cap = fpund_pkg::LIM;
		un  = mag64(num);
		ud  = mag64(den);
		q   = un / ud;
		rem = un % ud;
		if (q > cap) begin
			q = cap;
		end else begin
			for (int i = 0; i < sh; i++) begin
				q   = q << 1;
				rem = rem << 1;
				if (rem >= ud) begin
					rem = rem - ud;
					q   = q | 64'd1;
				end
				if (q > cap) begin
					q = cap;
					break;
				end
			end
		end
		r = signed'(q);
		return ((num < 0) != (den < 0)) ? -r : r;
	endfunction

	function automatic logic [63:0] radius_sqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = '0;
		b   = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n   = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// vectoring CORDIC: atan of r (Q.20) as Q.28, rounded
	function automatic logic signed [63:0] start_angle(logic [63:0] r);
		logic signed [63:0] cx, cy, z, dx, dy;
		cx = fpund_pkg::ONE_Q40;
		cy = signed'(r << 20);
		z  = '0;
		for (int i = 0; i < fpund_pkg::CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx; cy -= dy; z += fpund_pkg::ANGLE_TAB[i];
			end else begin
				cx -= dx; cy += dy; z -= fpund_pkg::ANGLE_TAB[i];
			end
		end
		return (z + (64'sd1 <<< 31)) >>> 32;
	endfunction

	// rotation CORDIC on theta reduced into [-pi/2, pi/2]; gain left in
	function automatic void rotate_angle(logic signed [63:0] theta,
			output logic signed [63:0] c, output logic signed [63:0] s);
		logic signed [63:0] z, cx, cy, dx, dy;
		z  = theta <<< 32;
		cx = fpund_pkg::ONE_Q40;
		cy = '0;
		while (z > fpund_pkg::HALF_PI_Q60) z -= fpund_pkg::PI_Q60;
		while (z < -fpund_pkg::HALF_PI_Q60) z += fpund_pkg::PI_Q60;
		for (int i = 0; i < fpund_pkg::CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx; cy += dy; z -= fpund_pkg::ANGLE_TAB[i];
			end else begin
				cx += dx; cy -= dy; z += fpund_pkg::ANGLE_TAB[i];
			end
		end
		c = cx;
		s = cy;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic undist_t undistort_point(point_t p);
		undist_t            res;
		logic signed [63:0] x, y, k1, k2, k3, k4, r28, theta, thd, fp, delta, scale, c, s;
		logic signed [63:0] t2, t3, t4, t5, t6, t7, t8, t9;
		logic [63:0]        r;
		bit                 conv;
		x     = p.x;
		y     = p.y;
		k1    = coeff[0];
		k2    = coeff[1];
		k3    = coeff[2];
		k4    = coeff[3];
		r     = radius_sqrt(mag64(x) * mag64(x) + mag64(y) * mag64(y));
		r28   = signed'(r << 8);
		theta = (r == 0) ? 64'sd0 : start_angle(r);
		thd   = '0;
		conv  = 1'b0;
		for (int it = 0; it < fpund_pkg::MAX_ITERATIONS; it++) begin
			t2  = fx_mul(theta, theta, 28);
			t3  = fx_mul(t2, theta, 28);
			t4  = fx_mul(t3, theta, 28);
			t5  = fx_mul(t4, theta, 28);
			t6  = fx_mul(t5, theta, 28);
			t7  = fx_mul(t6, theta, 28);
			t8  = fx_mul(t7, theta, 28);
			t9  = fx_mul(t8, theta, 28);
			thd = clamp58(theta + fx_mul(k1, t3, 24) + fx_mul(k2, t5, 24)
				+ fx_mul(k3, t7, 24) + fx_mul(k4, t9, 24));
			fp  = clamp58(fpund_pkg::ONE_Q28 + 3 * fx_mul(k1, t2, 24) + 5 * fx_mul(k2, t4, 24)
				+ 7 * fx_mul(k3, t6, 24) + 9 * fx_mul(k4, t8, 24));
			delta = fx_div(r28 - thd, fp, 28);
			if (delta > -fpund_pkg::TOL_Q28 && delta < fpund_pkg::TOL_Q28) begin
				conv = 1'b1;
				break;
			end
			theta += delta;
			if (theta > 64'sd2147483647) theta = 64'sd2147483647;
			if (theta < -64'sd2147483648) theta = -64'sd2147483648;
		end
		res.x = p.x;
		res.y = p.y;
		if (!conv) begin
			res.st = fpund_pkg::STAT_NOCONV;
			return res;
		end
		if (thd == 0) begin
			scale = fpund_pkg::ONE_Q40;
		end else begin
			rotate_angle(theta, c, s);
			scale = fx_div(s, fx_mul(c, thd, 28), 40);
		end
		if (scale < 0) begin
			res.st = fpund_pkg::STAT_NEGSCALE;
			return res;
		end
		res.x  = sat32(fx_mul(x, scale, 40));
		res.y  = sat32(fx_mul(y, scale, 40));
		res.st = fpund_pkg::STAT_OK;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// request driver: hold a stalled request, otherwise idle in random bursts unless calm
	always @(posedge clk) begin
		logic nxt_v;
		bit   fire;
		fire = in_valid && !in_stall;
		if (fire) begin
			expected_points.push_back(undistort_point(pending_points[0]));
			void'(pending_points.pop_front());
		end
		if (in_valid && !fire) begin
			nxt_v = 1'b1;
		end else if (pending_points.size() == 0) begin
			nxt_v = 1'b0;
		end else if (!calm && tx_gap > 0) begin
			tx_gap--;
			nxt_v = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			tx_gap = $urandom_range(0, 9);
			nxt_v  = 1'b0;
		end else begin
			nxt_v = 1'b1;
		end
		in_valid <= nxt_v;
		if (nxt_v) begin
			x_in <= pending_points[0].x;
			y_in <= pending_points[0].y;
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		undist_t e;
		logic    nxt_s;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected result x", x_out, 0);
			end else begin
				e = expected_points.pop_front();
				if (x_out !== e.x) report_mismatch("x_out", x_out, e.x);
				if (y_out !== e.y) report_mismatch("y_out", y_out, e.y);
				if (status !== e.st) report_mismatch("status", status, e.st);
			end
			n_results++;
		end
		// one long hold-off so that the block backs up onto its input
		if (n_results == 300 && !hold_done) begin
			hold_cnt  = 6000;
			hold_done = 1'b1;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			nxt_s = 1'b1;
		end else if (calm) begin
			nxt_s = 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			nxt_s = 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(0, 9);
			nxt_s  = 1'b1;
		end else begin
			nxt_s = 1'b0;
		end
		out_stall <= nxt_s;
	end

	task automatic write_coeffs(logic signed [31:0] k1, logic signed [31:0] k2,
			logic signed [31:0] k3, logic signed [31:0] k4);
		@(posedge clk) begin wr_en <= 1'b1; wr_index <= REG_K1; wr_data <= k1; end
		@(posedge clk) begin wr_index <= REG_K2; wr_data <= k2; end
		@(posedge clk) begin wr_index <= REG_K3; wr_data <= k3; end
		@(posedge clk) begin wr_index <= REG_K4; wr_data <= k4; end
		@(posedge clk) wr_en <= 1'b0;
		coeff[0] = k1;
		coeff[1] = k2;
		coeff[2] = k3;
		coeff[3] = k4;
	endtask

	task automatic add_point(logic signed [31:0] x, logic signed [31:0] y);
		point_t p;
		p.x = x;
		p.y = y;
		pending_points.push_back(p);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			7:       return $urandom;
			8:       return 32'sd0;
			9:       return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
			default: return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_small_coeff();
		return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
	endfunction

	task automatic wait_drained();
		wait (pending_points.size() == 0 && expected_points.size() == 0 && !in_valid);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain equidistant lens first: origin, axes, extremes, pole and wrap-round
		write_coeffs(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		add_point(32'sd0, 32'sd0);
		add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		add_point(32'sh8000_0000, 32'sh8000_0000);
		add_point(32'sh8000_0000, 32'sd0);
		add_point(32'sd0, 32'sh7FFF_FFFF);
		add_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		add_point(32'sd1, 32'sd0);
		add_point(-32'sd1, -32'sd1);
		add_point(32'sd1 <<< 20, 32'sd0);
		add_point(32'sd0, -(32'sd1 <<< 20));
		add_point(32'sd3 <<< 20, 32'sd0);
		add_point(32'sd1647099, 32'sd0);
		add_point(32'sh0010_0000, 32'sh0010_0000);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_coeffs(-32'sd167772, 32'sd16777, -32'sd1677, 32'sd167);
				1: write_coeffs(rand_small_coeff(), rand_small_coeff(), rand_small_coeff(),
					rand_small_coeff());
				2: write_coeffs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
				3: write_coeffs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
				4: write_coeffs($urandom, $urandom, $urandom, $urandom);
				default: begin
					write_coeffs(32'sd83886, -32'sd8388, 32'sd838, -32'sd83);
					calm = 1'b1;
				end
			endcase
			for (int n = 0; n < 200; n++) add_point(rand_coord(), rand_coord());
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (n_errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#400000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: filelist.f
sv/fpund_pkg.sv
sv/fisheye_point_undistort.sv
sv/fpund_checker.sv
tb/fisheye_point_undistort_test.sv
